// File: sv/lkvc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the key/value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W   = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the accepted item
        logic exec_set;  // apply the latched set to the table
        logic load_out;  // capture the lookup result into the output register
    } dp_cmd_t;

    // datapath -> controller (and checks)
    typedef struct packed {
        logic               item_is_set;
        logic [CNT_W-1:0]   entry_count;
        logic [ENTRIES-1:0] valid_vec;
    } dp_stat_t;

endpackage

// File: sv/lkvc_datapath.sv
// Entry table, parallel key match, recency ranks and output register.
module lkvc_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lkvc_pkg::dp_cmd_t      cmd,
    output lkvc_pkg::dp_stat_t     stat,
    input  lkvc_pkg::cmd_t         in_cmd,
    input  logic [31:0]            in_key,
    input  logic [31:0]            in_value,
    input  logic                   cfg_we,
    input  logic [4:0]             cfg_data,
    output logic                   out_hit,
    output logic [31:0]            out_value
);
    import lkvc_pkg::*;

    logic               valid_reg [ENTRIES];
    logic [KEY_W-1:0]   key_reg   [ENTRIES];
    logic [VAL_W-1:0]   data_reg  [ENTRIES];
    logic [AGE_W-1:0]   age_reg   [ENTRIES];
    logic [AGE_W-1:0]   age_next  [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CAP_W-1:0]   cap_reg;

    cmd_t               item_cmd_reg;
    logic [KEY_W-1:0]   item_key_reg;
    logic [VAL_W-1:0]   item_val_reg;
    logic               out_hit_reg;
    logic [VAL_W-1:0]   out_value_reg;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] valid_vec;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx, free_idx, victim_idx, slot;
    logic [CMP_W-1:0]   eff_cap;
    logic               evict;
    logic [CNT_W-1:0]   thresh;
    logic [CNT_W-1:0]   oldest;

    always_comb begin
        eff_cap = CMP_W'(cap_reg);
        if (cap_reg == '0)
            eff_cap = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
    end

    assign evict  = CMP_W'(count_reg) >= eff_cap;
    assign oldest = count_reg - CNT_W'(1);

    always_comb begin
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i]     = valid_reg[i] && (key_reg[i] == item_key_reg);
            valid_vec[i] = valid_reg[i];
            if (match[i])
                hit_idx = IDX_W'(i);
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
            // ranks form a permutation of 0..count-1, so the oldest is unique
            if (valid_reg[i] && (CNT_W'(age_reg[i]) == oldest))
                victim_idx = IDX_W'(i);
        end
    end

    assign hit = |match;

    always_comb begin
        if (hit) begin
            slot   = hit_idx;
            thresh = CNT_W'(age_reg[hit_idx]);
        end else if (evict) begin
            slot   = victim_idx;
            thresh = oldest;
        end else begin
            slot   = free_idx;
            thresh = CNT_W'(ENTRIES);   // every other valid entry ages
        end
        for (int i = 0; i < ENTRIES; i++) begin
            age_next[i] = age_reg[i];
            if (IDX_W'(i) == slot)
                age_next[i] = '0;
            else if (valid_reg[i] && (CNT_W'(age_reg[i]) < thresh))
                age_next[i] = age_reg[i] + AGE_W'(1);
        end
    end

    // control state: valid bits, ranks, count, capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= '0;
            end
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (cmd.exec_set) begin
                for (int i = 0; i < ENTRIES; i++)
                    age_reg[i] <= age_next[i];
                if (!hit && !evict) begin
                    valid_reg[free_idx] <= 1'b1;
                    count_reg           <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_cmd_reg <= in_cmd;
            item_key_reg <= in_key;
            item_val_reg <= in_value;
        end
        if (cmd.exec_set) begin
            key_reg[slot]  <= item_key_reg;
            data_reg[slot] <= item_val_reg;
        end
        if (cmd.load_out) begin
            out_hit_reg   <= hit;
            out_value_reg <= hit ? data_reg[hit_idx] : '0;
        end
    end

    assign out_hit          = out_hit_reg;
    assign out_value        = out_value_reg;
    assign stat.item_is_set = (item_cmd_reg == CMD_SET);
    assign stat.entry_count = count_reg;
    assign stat.valid_vec   = valid_vec;

endmodule

// File: sv/lkvc_ctrl.sv
// Item sequencer: accepts one item, executes it, hands gets to the output register.
module lkvc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lkvc_pkg::dp_cmd_t   cmd,
    input  lkvc_pkg::dp_stat_t  stat
);
    import lkvc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.item_is_set) begin
                    cmd.exec_set = 1'b1;
                    state_next   = ST_IDLE;
                end else if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/lru_key_value_cache.sv
// Top level of the fully associative key/value cache with least-recently-set replacement.
//
//  channel   dir   handshake               payload
//  --------  ----  ----------------------  -------------------------------------------
//  s_        in    s_tvalid / s_tready     s_tuser: cmd (0 get, 1 set)
//                                          s_tdata: [31:0] lookup_key, [63:32] write_value
//  m_        out   m_tvalid / m_tready     m_tuser: hit
//                                          m_tdata: [31:0] read_value (zero on miss)
//  cfg_      in    cfg_valid / cfg_ready   cfg_data: [4:0] capacity (0 acts as 1, >16 as 16)
//
// Each item is accepted and latched in idle; in execute all entries compare their keys in
// parallel; a set updates the ranks, key and value, a get loads the output register.
// A get leaves one item on m_ per lookup; a set produces none.
// Reset clears valid bits, ranks and the count at once (no sweep) and sets capacity to 16.
// A get that finds the output register still full waits in execute, holding s_tready low.
// cfg_ready is always high; the user must see that capacity is only written while the cache is idle (not enforced).
module lru_key_value_cache (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lookup_key [31:0], write_value [63:32]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value [31:0]
    output logic        m_tuser,   // hit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import lkvc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lkvc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_cmd    (cmd_t'(s_tuser)),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_hit   (m_tuser),
        .out_value (m_tdata)
    );

    // the block is busy the cycle after it takes an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still executing");

    // fill count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(stat.valid_vec) == int'(stat.entry_count))
        else $error("entry count out of step with valid bits");

    // a miss always returns zero data
    a_miss_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss returned nonzero data");

    // a set never produces a result item
    a_set_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && cmd.exec_set) |=> !m_tvalid)
        else $error("set produced a result item");

endmodule
